/* rtl/ksm_pkg.sv */
// package for the keyed slot map: operation, status and state codes, sizes, cell control struct
// no dependencies
package ksm_pkg;

  localparam int SlotsDefault   = 64;
  localparam int KeyBitsDefault = 32;

  localparam int OpW     = 3;
  localparam int StatusW = 3;

  typedef enum logic [OpW-1:0] {
    OP_LOOKUP   = 3'd0,
    OP_INSERT   = 3'd1,
    OP_MOVE     = 3'd2,
    OP_ERASE    = 3'd3,
    OP_CLEAR    = 3'd4,
    OP_PREALLOC = 3'd5
  } op_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_EXISTS    = 3'd2,
    ST_NO_FREE   = 3'd3,
    ST_NO_MEMORY = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_CLEAR,
    S_PREALLOC,
    S_DONE
  } state_t;

  // broadcast control into every cell
  typedef struct packed {
    logic write_key;   // load key into the addressed cell
    logic set_used;    // mark addressed cell used
    logic clr_used;    // mark addressed cell free
  } cell_ctl_t;

endpackage

/* rtl/keyed_slot_map_with_free_pool_top.sv */
// top level of the keyed slot map with free pool: command sequencer, cell row,
// free-slot stack ram; depends on ksm_pkg, ksm_cell, ksm_ram
//
// usage
//   s_axis carries one command per transfer, m_axis returns exactly one result
//   per command. one command is worked on at a time; s_axis_tready is low
//   from acceptance until the result has been taken on m_axis.
//   lookup, insert, move, erase: the keys are broadcast to the row of cells,
//   each cell compares its stored key, and the hit vector is encoded into a
//   slot number. after the command transfer the steps compare, registered
//   encode and action run before the result is offered. the top-of-stack
//   read of the free ram is hidden in this wait.
//   clear: the row acts as a registered minimum chain; each pass ripples the
//   smallest used key to the end, which is then pushed onto the free stack.
//   passes repeat until no used key reaches the end, then the result is offered.
//   prealloc: one new slot is pushed per cycle, highest first, so the lowest
//   new slot ends on top.
//   unused operation codes offer their result in the cycle after the transfer.
//   reset (rst, synchronous) clears the used flags, the free count and the
//   created count; key and stack contents need no clearing.
//   when m_axis_tready is low the result is held in the output register.
module keyed_slot_map_with_free_pool_top #(
  parameter int SLOTS    = ksm_pkg::SlotsDefault,
  parameter int KEY_BITS = ksm_pkg::KeyBitsDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // operation[2:0], key[34:3], target_key[66:35], wanted_free[73:67], zero fill
  input  logic [79:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[2:0], slot[8:3], free_slots[15:9]
  output logic [15:0]  m_axis_tdata
);

  localparam int IdxW = $clog2(SLOTS);
  localparam int CntW = $clog2(SLOTS + 1);

  // captured command
  ksm_pkg::op_t        op;
  logic [KEY_BITS-1:0] key;
  logic [KEY_BITS-1:0] tkey;
  logic [6:0]          wanted;

  ksm_pkg::state_t state, state_next;
  logic [CntW-1:0] free_count;
  logic [CntW-1:0] created;
  logic [CntW-1:0] wait_cnt;   // search settle / min chain ripple counter
  logic [CntW-1:0] pre_left;   // slots still to create in prealloc
  logic [CntW-1:0] need_total; // total created in this prealloc, kept from the start

  ksm_pkg::status_t res_status;
  logic [5:0]       res_slot;

  // cell row wiring
  ksm_pkg::cell_ctl_t  ctl;
  logic [IdxW-1:0]     cell_addr;
  logic [KEY_BITS-1:0] cell_wkey;
  logic [SLOTS-1:0]    hit_a, hit_b;
  logic [SLOTS:0]      mv;
  logic [KEY_BITS-1:0] mk [SLOTS+1];
  logic [IdxW-1:0]     mi [SLOTS+1];

  // hit vector registered and encoded
  logic            found_a, found_b;
  logic [IdxW-1:0] slot_a;

  // free stack ram
  logic            st_we;
  logic [IdxW-1:0] st_waddr, st_raddr;
  logic [IdxW-1:0] st_wdata, st_rdata;

  logic in_acc, out_acc;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (state == ksm_pkg::S_IDLE);
  assign m_axis_tvalid = (state == ksm_pkg::S_DONE);
  assign m_axis_tdata  = {7'(free_count), res_slot, res_status};

  assign mv[0] = 1'b0;
  assign mk[0] = '0;
  assign mi[0] = '0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    ksm_cell #(.KeyBits(KEY_BITS), .IdxW(IdxW), .Index(g)) u_cell (
      .clk, .rst, .ctl, .addr(cell_addr), .wr_key(cell_wkey),
      .key_a(key), .key_b(tkey),
      .min_in_valid(mv[g]), .min_in_key(mk[g]), .min_in_idx(mi[g]),
      .min_out_valid(mv[g+1]), .min_out_key(mk[g+1]), .min_out_idx(mi[g+1]),
      .hit_a(hit_a[g]), .hit_b(hit_b[g])
    );
  end

  // one-hot hit vector to index, keys are unique so at most one bit is set
  always_ff @(posedge clk) begin
    logic [IdxW-1:0] enc;
    enc = '0;
    for (int i = 0; i < SLOTS; i++) begin
      enc = enc | (hit_a[i] ? IdxW'(i) : '0);
    end
    found_a <= |hit_a;
    found_b <= |hit_b;
    slot_a  <= enc;
  end

  ksm_ram #(.Width(IdxW), .Depth(SLOTS)) u_stack (
    .clk, .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );
  // top of stack stays readable in the search wait
  assign st_raddr = IdxW'(free_count - 1'b1);

  // combinational action decisions for the end of the search and for clear and prealloc pushes
  logic search_end;
  logic do_insert, do_move, do_drop, clr_push, pre_push;
  logic [CntW-1:0] need;
  assign search_end = (state == ksm_pkg::S_SEARCH) && (wait_cnt == CntW'(2));
  assign need = CntW'(wanted) - free_count;

  assign do_insert = search_end && op == ksm_pkg::OP_INSERT && free_count != '0 && !found_a;
  assign do_move   = search_end && op == ksm_pkg::OP_MOVE && found_a && tkey != key
                     && !found_b;
  assign do_drop   = search_end && found_a && ((op == ksm_pkg::OP_ERASE) ||
                     (op == ksm_pkg::OP_MOVE && tkey != key && found_b));
  // min chain has settled when wait_cnt reaches SLOTS and the end is valid
  assign clr_push  = (state == ksm_pkg::S_CLEAR) && wait_cnt == CntW'(SLOTS) && mv[SLOTS];
  assign pre_push  = (state == ksm_pkg::S_PREALLOC) && pre_left != '0;

  always_comb begin
    ctl       = '0;
    cell_addr = slot_a;
    cell_wkey = key;
    st_we     = 1'b0;
    st_waddr  = IdxW'(free_count);
    st_wdata  = slot_a;
    if (do_insert) begin
      ctl.write_key = 1'b1;
      ctl.set_used  = 1'b1;
      cell_addr     = st_rdata;
    end else if (do_move) begin
      ctl.write_key = 1'b1;
      cell_wkey     = tkey;
    end else if (do_drop) begin
      ctl.clr_used = 1'b1;
      st_we        = free_count < CntW'(SLOTS);
    end else if (clr_push) begin
      ctl.clr_used = 1'b1;
      cell_addr    = mi[SLOTS];
      st_wdata     = mi[SLOTS];
      st_we        = free_count < CntW'(SLOTS);
    end else if (pre_push) begin
      st_we    = 1'b1;
      st_wdata = IdxW'(created + pre_left - 1'b1);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ksm_pkg::S_IDLE: begin
        if (in_acc) begin
          case (ksm_pkg::op_t'(s_axis_tdata[2:0]))
            ksm_pkg::OP_LOOKUP, ksm_pkg::OP_INSERT,
            ksm_pkg::OP_MOVE, ksm_pkg::OP_ERASE: state_next = ksm_pkg::S_SEARCH;
            ksm_pkg::OP_CLEAR:    state_next = ksm_pkg::S_CLEAR;
            ksm_pkg::OP_PREALLOC: state_next = ksm_pkg::S_PREALLOC;
            default:              state_next = ksm_pkg::S_DONE;
          endcase
        end
      end
      ksm_pkg::S_SEARCH:   if (search_end) state_next = ksm_pkg::S_DONE;
      ksm_pkg::S_CLEAR: begin
        if (wait_cnt == CntW'(SLOTS) && !mv[SLOTS]) state_next = ksm_pkg::S_DONE;
      end
      ksm_pkg::S_PREALLOC: if (!pre_push && wait_cnt != '0) state_next = ksm_pkg::S_DONE;
      ksm_pkg::S_DONE:     if (out_acc) state_next = ksm_pkg::S_IDLE;
      default:             state_next = ksm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ksm_pkg::S_IDLE;
      free_count <= '0;
      created    <= '0;
      wait_cnt   <= '0;
      pre_left   <= '0;
      res_status <= ksm_pkg::ST_OK;
      res_slot   <= '0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        wait_cnt   <= '0;
        pre_left   <= '0;
        res_status <= ksm_pkg::ST_OK;
        res_slot   <= '0;
      end
      case (state)
        ksm_pkg::S_SEARCH: begin
          wait_cnt <= wait_cnt + 1'b1;
          if (search_end) begin
            case (op)
              ksm_pkg::OP_LOOKUP: begin
                if (found_a) res_slot <= 6'(slot_a);
                else res_status <= ksm_pkg::ST_NOT_FOUND;
              end
              ksm_pkg::OP_INSERT: begin
                if (free_count == '0) res_status <= ksm_pkg::ST_NO_FREE;
                else if (found_a) res_status <= ksm_pkg::ST_EXISTS;
                else begin
                  res_slot   <= 6'(st_rdata);
                  free_count <= free_count - 1'b1;
                end
              end
              ksm_pkg::OP_MOVE: begin
                if (!found_a) res_status <= ksm_pkg::ST_NOT_FOUND;
                else if (tkey == key || !found_b) res_slot <= 6'(slot_a);
                else begin
                  res_status <= ksm_pkg::ST_EXISTS;
                  if (free_count < CntW'(SLOTS)) free_count <= free_count + 1'b1;
                end
              end
              ksm_pkg::OP_ERASE: begin
                if (!found_a) res_status <= ksm_pkg::ST_NOT_FOUND;
                else begin
                  res_slot <= 6'(slot_a);
                  if (free_count < CntW'(SLOTS)) free_count <= free_count + 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        ksm_pkg::S_CLEAR: begin
          // restart the ripple after each push so the cleared cell drops out
          if (wait_cnt == CntW'(SLOTS)) begin
            wait_cnt <= '0;
            if (clr_push && free_count < CntW'(SLOTS)) free_count <= free_count + 1'b1;
          end else begin
            wait_cnt <= wait_cnt + 1'b1;
          end
        end
        ksm_pkg::S_PREALLOC: begin
          if (wait_cnt == '0) begin
            wait_cnt <= CntW'(1);
            if (32'(wanted) > 32'(free_count)) begin
              if (32'(wanted) > 32'(SLOTS) ||
                  need > CntW'(SLOTS) - created) begin
                res_status <= ksm_pkg::ST_NO_MEMORY;
              end else begin
                pre_left <= need;
              end
            end
          end else if (pre_push) begin
            pre_left   <= pre_left - 1'b1;
            free_count <= free_count + 1'b1;
            if (pre_left == CntW'(1)) created <= created + need_total;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ksm_pkg::S_PREALLOC && wait_cnt == '0) need_total <= need;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op     <= ksm_pkg::op_t'(s_axis_tdata[2:0]);
      key    <= KEY_BITS'(s_axis_tdata[34:3]);
      tkey   <= KEY_BITS'(s_axis_tdata[66:35]);
      wanted <= s_axis_tdata[73:67];
    end
  end

endmodule

/* rtl/ksm_cell.sv */
// one map cell: holds a key and a used flag, compares against two search keys
// and passes the running minimum-key candidate on to its neighbor
// depends on ksm_pkg
module ksm_cell #(
  parameter int KeyBits = ksm_pkg::KeyBitsDefault,
  parameter int IdxW    = 6,
  parameter int Index   = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  ksm_pkg::cell_ctl_t  ctl,
  input  logic [IdxW-1:0]     addr,
  input  logic [KeyBits-1:0]  wr_key,
  input  logic [KeyBits-1:0]  key_a,
  input  logic [KeyBits-1:0]  key_b,
  // minimum chain from the lower neighbor
  input  logic                min_in_valid,
  input  logic [KeyBits-1:0]  min_in_key,
  input  logic [IdxW-1:0]     min_in_idx,
  output logic                min_out_valid,
  output logic [KeyBits-1:0]  min_out_key,
  output logic [IdxW-1:0]     min_out_idx,
  output logic                hit_a,
  output logic                hit_b
);

  logic               used;
  logic [KeyBits-1:0] key;
  logic               sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (addr == IdxW'(Index)) begin
      if (ctl.set_used) begin
        used <= 1'b1;
      end else if (ctl.clr_used) begin
        used <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.write_key && addr == IdxW'(Index)) begin
      key <= wr_key;
    end
  end

  assign hit_a = used && (key == key_a);
  assign hit_b = used && (key == key_b);

  // strict less keeps the lowest index on equal keys (keys are unique anyway)
  assign sel = used && (!min_in_valid || key < min_in_key);

  // chain registered in each cell to keep the path to one compare per cell
  always_ff @(posedge clk) begin
    if (rst) begin
      min_out_valid <= 1'b0;
    end else begin
      min_out_valid <= min_in_valid || used;
    end
  end

  always_ff @(posedge clk) begin
    min_out_key <= sel ? key : min_in_key;
    min_out_idx <= sel ? IdxW'(Index) : min_in_idx;
  end

endmodule

/* rtl/ksm_ram.sv */
// generic single-port-write, one-read ram with registered read
// no dependencies
module ksm_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
